### hdl/mct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and defaults for the min Cartesian tree builder: sequencer
// states, the status and command structs between sequencer and datapath,
// and parameter defaults.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IDX_OUT_W       = 10;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic in_valid;
        logic ovf;
        logic depth_nz;
        logic top_gt;
        logic out_free;
    } t_ctrl_status;

    // Step commands from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic pop;
        logic finish;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

### hdl/mct_stack_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mct_stack_ram
// Stack store of (index, value) pairs: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mct_stack_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 42
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### hdl/mct_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mct_ctrl
// Sequencer: takes an item, pops one stack entry per cycle while the top is
// greater than the new value, then finishes the item when the output
// register can take its result.
// ----------------------------------------------------------------------------
module mct_ctrl
    import mct_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_ctrl_status i_status,
    output t_ctrl_cmd         o_cmd,
    output logic              o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle       = 1'b1;
                o_cmd.accept = i_status.in_valid;
            end
            ST_RUN: begin
                if (!i_status.ovf && i_status.depth_nz && i_status.top_gt) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.finish = i_status.out_free;
                end
            end
            default: o_idle = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### hdl/min_cartesian_tree_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_cartesian_tree_builder
// Builds a min Cartesian tree from a stream of array values with a monotone
// stack, giving one result item per input item.
// ----------------------------------------------------------------------------
// Each input item carries one array value (signed) and a flag for the last
// element. The block keeps a stack of (index, value) pairs in a memory of
// MAX_ITEMS entries, with the top entry also held in registers. An item is
// handled in steps: the item is taken, stack entries are popped one at a
// time, and then the new entry is pushed and the result posted. The single
// comparator between the new value and the stack top limits pops to one at a
// time; the entry below the top comes out of the memory read port in the
// cycle after each pop, and every element is popped at most once over a
// whole array, so pops never outnumber items. The block takes no new item
// while one is in work, but a finished result waits in its own output
// register, so the next item is taken while the result is still stalled.
// Entries with values strictly greater than the new value are popped, so equal
// values keep the earlier element as the ancestor. The result names the new
// node's parent (the remaining top, which takes the node as right child) and
// its left child (the last entry popped). On the last element the root is
// reported and the stack and position counter are cleared. Items beyond
// MAX_ITEMS in one array are dropped and flagged as overflow. Index fields
// carry the low ten bits of each position. The stack memory needs no clearing
// after reset: only entries below the stack depth are ever read.
// ----------------------------------------------------------------------------
module min_cartesian_tree_builder
    import mct_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_last_item,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [IDX_OUT_W-1:0]        o_node_index,
    output logic                        o_has_parent,
    output logic [IDX_OUT_W-1:0]        o_parent_index,
    output logic                        o_has_left,
    output logic [IDX_OUT_W-1:0]        o_left_index,
    output logic                        o_end_of_array,
    output logic [IDX_OUT_W-1:0]        o_root_index,
    output logic                        o_overflow
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int DW = $clog2(MAX_ITEMS + 1);
    localparam int EW = IW + VALUE_WIDTH;
    localparam logic [DW-1:0] CAPACITY = DW'(MAX_ITEMS);

    // Sequencer interface.
    t_ctrl_status w_status;
    t_ctrl_cmd    w_cmd;
    logic         w_idle;

    // Item in work.
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic                          r_last;
    logic                          r_ovf;
    logic                          r_popped;
    logic [IW-1:0]                 r_lpop;

    // Stack state.
    logic [DW-1:0]                 r_depth;
    logic [DW-1:0]                 r_next;
    logic [IW-1:0]                 r_top_idx;
    logic signed [VALUE_WIDTH-1:0] r_top_val;
    logic                          r_rd_pend;
    logic [IW-1:0]                 r_root;

    // Output register.
    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_node;
    logic                 r_has_par;
    logic [IDX_OUT_W-1:0] r_par;
    logic                 r_has_left;
    logic [IDX_OUT_W-1:0] r_left;
    logic                 r_eoa;
    logic [IDX_OUT_W-1:0] r_root_out;
    logic                 r_ovf_out;

    // Memory ports.
    logic [EW-1:0] w_rd_data;
    logic [EW-1:0] w_wr_data;
    logic [IW-1:0] w_wr_addr;
    logic [IW-1:0] w_rd_addr;
    logic [DW-1:0] w_below;
    logic          w_rd_en;

    // Current stack top: straight from the read port right after a pop.
    logic [IW-1:0]                 w_cur_idx;
    logic signed [VALUE_WIDTH-1:0] w_cur_val;
    logic [IW-1:0]                 w_me;
    logic                          w_depth_nz;
    logic [IW-1:0]                 w_root_idx;

    assign w_cur_idx  = r_rd_pend ? w_rd_data[EW-1:VALUE_WIDTH] : r_top_idx;
    assign w_cur_val  = r_rd_pend ? $signed(w_rd_data[VALUE_WIDTH-1:0]) : r_top_val;
    assign w_me       = r_next[IW-1:0];
    assign w_depth_nz = (r_depth != '0);

    // The entry under the current top sits at depth - 2.
    assign w_below   = r_depth - DW'(2);
    assign w_rd_addr = w_below[IW-1:0];
    assign w_rd_en   = w_cmd.pop && (r_depth > DW'(1));

    assign w_wr_addr = r_depth[IW-1:0];
    assign w_wr_data = {w_me, r_key};

    // The root is the stack bottom, which changes only on a push into an
    // empty stack.
    assign w_root_idx = w_depth_nz ? r_root : w_me;

    assign w_status.in_valid = i_valid;
    assign w_status.ovf      = r_ovf;
    assign w_status.depth_nz = w_depth_nz;
    assign w_status.top_gt   = (w_cur_val > r_key);
    assign w_status.out_free = !r_out_valid || !i_stall;

    mct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_idle   (w_idle)
    );

    mct_stack_ram #(
        .DEPTH  (MAX_ITEMS),
        .DATA_W (EW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_cmd.finish && !r_ovf),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Positions are shown by their low ten bits.
    function automatic logic [IDX_OUT_W-1:0] f_out_idx(input logic [IW-1:0] idx);
        logic [IW+IDX_OUT_W-1:0] ext;
        ext = {{IDX_OUT_W{1'b0}}, idx};
        return ext[IDX_OUT_W-1:0];
    endfunction

    // Control state of the stack and the item in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_next    <= '0;
            r_rd_pend <= 1'b0;
            r_ovf     <= 1'b0;
            r_popped  <= 1'b0;
        end else begin
            if (w_cmd.accept) begin
                r_ovf     <= (r_next == CAPACITY);
                r_popped  <= 1'b0;
                r_rd_pend <= 1'b0;
            end else if (w_cmd.pop) begin
                r_popped  <= 1'b1;
                r_depth   <= r_depth - DW'(1);
                r_rd_pend <= (r_depth > DW'(1));
            end else if (w_cmd.finish) begin
                r_rd_pend <= 1'b0;
                if (r_last) begin
                    r_depth <= '0;
                    r_next  <= '0;
                end else if (!r_ovf) begin
                    r_depth <= r_depth + DW'(1);
                    r_next  <= r_next + DW'(1);
                end
            end
        end
    end

    // Payload of the item in work and the cached stack top.
    always_ff @(posedge i_clk) begin
        if (w_cmd.accept) begin
            r_key  <= $signed(i_value);
            r_last <= i_last_item;
        end
        if (w_cmd.pop) begin
            r_lpop <= w_cur_idx;
        end
        if (w_cmd.finish && !r_ovf) begin
            r_top_idx <= w_me;
            r_top_val <= r_key;
            if (!w_depth_nz) begin
                r_root <= w_me;
            end
        end
    end

    // Output register: loaded when an item finishes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_eoa     <= r_last;
            r_ovf_out <= r_ovf;
            if (r_ovf) begin
                r_node     <= '0;
                r_has_par  <= 1'b0;
                r_par      <= '0;
                r_has_left <= 1'b0;
                r_left     <= '0;
                r_root_out <= (r_last && w_depth_nz) ? f_out_idx(r_root) : '0;
            end else begin
                r_node     <= f_out_idx(w_me);
                r_has_par  <= w_depth_nz;
                r_par      <= w_depth_nz ? f_out_idx(w_cur_idx) : '0;
                r_has_left <= r_popped;
                r_left     <= r_popped ? f_out_idx(r_lpop) : '0;
                r_root_out <= r_last ? f_out_idx(w_root_idx) : '0;
            end
        end
    end

    assign o_stall        = !w_idle;
    assign o_valid        = r_out_valid;
    assign o_node_index   = r_node;
    assign o_has_parent   = r_has_par;
    assign o_parent_index = r_par;
    assign o_has_left     = r_has_left;
    assign o_left_index   = r_left;
    assign o_end_of_array = r_eoa;
    assign o_root_index   = r_root_out;
    assign o_overflow     = r_ovf_out;

endmodule
`default_nettype wire

### verif/mct_link_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mct_link_checker
// Watches both channels of the min Cartesian tree builder, predicts the tree
// links of every accepted item and compares them with the results.
// ----------------------------------------------------------------------------
module mct_link_checker
    import mct_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_in_value,
    input  wire logic                   i_in_last,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [IDX_OUT_W-1:0]   i_node_index,
    input  wire logic                   i_has_parent,
    input  wire logic [IDX_OUT_W-1:0]   i_parent_index,
    input  wire logic                   i_has_left,
    input  wire logic [IDX_OUT_W-1:0]   i_left_index,
    input  wire logic                   i_end_of_array,
    input  wire logic [IDX_OUT_W-1:0]   i_root_index,
    input  wire logic                   i_overflow,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] node_index;
        logic                 has_parent;
        logic [IDX_OUT_W-1:0] parent_index;
        logic                 has_left;
        logic [IDX_OUT_W-1:0] left_index;
        logic                 end_of_array;
        logic [IDX_OUT_W-1:0] root_index;
        logic                 overflow;
    } t_tree_link;

    t_tree_link                    link_queue[$];
    int unsigned                   stack_pos [MAX_ITEMS];
    logic signed [VALUE_WIDTH-1:0] stack_val [MAX_ITEMS];
    int unsigned                   stack_depth = 0;
    int unsigned                   next_pos    = 0;
    int                            fail_count  = 0;
    int                            pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Monotone stack step: pop strictly greater entries, link, then push.
    task automatic predict_link(input logic signed [VALUE_WIDTH-1:0] value,
                                input logic last, output t_tree_link link);
        int unsigned me;
        bit          popped;
        int unsigned last_pop;
        link = '0;
        if (next_pos >= MAX_ITEMS) begin
            link.overflow = 1'b1;
        end else begin
            me       = next_pos;
            popped   = 1'b0;
            last_pop = 0;
            while (stack_depth > 0 && stack_val[stack_depth-1] > value) begin
                last_pop = stack_pos[stack_depth-1];
                popped   = 1'b1;
                stack_depth--;
            end
            if (stack_depth > 0) begin
                link.has_parent   = 1'b1;
                link.parent_index = IDX_OUT_W'(stack_pos[stack_depth-1]);
            end
            if (popped) begin
                link.has_left   = 1'b1;
                link.left_index = IDX_OUT_W'(last_pop);
            end
            stack_pos[stack_depth] = me;
            stack_val[stack_depth] = value;
            stack_depth++;
            link.node_index = IDX_OUT_W'(me);
            next_pos = me + 1;
        end
        link.end_of_array = last;
        if (last) begin
            if (stack_depth > 0) begin
                link.root_index = IDX_OUT_W'(stack_pos[0]);
            end
            stack_depth = 0;
            next_pos    = 0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tree_link want;
        if (!i_rst_n) begin
            link_queue.delete();
            stack_depth = 0;
            next_pos    = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_link(i_in_value, i_in_last, want);
                link_queue = {link_queue, want};
            end
            if (i_out_valid && !i_out_stall) begin
                if (link_queue.size() == 0) begin
                    $error("result with no item waiting: node_index %0d", i_node_index);
                    fail_count++;
                end else begin
                    want = link_queue.pop_front();
                    check_field("node_index",   want.node_index,   i_node_index);
                    check_field("has_parent",   want.has_parent,   i_has_parent);
                    check_field("parent_index", want.parent_index, i_parent_index);
                    check_field("has_left",     want.has_left,     i_has_left);
                    check_field("left_index",   want.left_index,   i_left_index);
                    check_field("end_of_array", want.end_of_array, i_end_of_array);
                    check_field("root_index",   want.root_index,   i_root_index);
                    check_field("overflow",     want.overflow,     i_overflow);
                end
            end
        end
        pending_count = link_queue.size();
    end

endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the min Cartesian tree builder.
// ----------------------------------------------------------------------------
// The sender offers arrays of values, one item per element, with the last
// flag on each array's final element. A short directed part covers a single
// element array, ties, the extreme values and a long pop chain. The random
// part sends many short arrays with different value patterns (full range,
// a narrow range full of ties, slowly rising runs with drops, extremes only)
// and one array longer than the capacity, so that the tail items are dropped
// and the last one is an overflow item that still reports the root.
// Both sides idle at random, with one quiet stretch on each side. Early on the
// receiver holds off for a long stretch while the sender keeps offering, so
// the block fills and stalls its input. After the long array the sender waits
// until every expected result has come. The checker beside the block does all
// prediction and comparison; this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import mct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W       = VALUE_WIDTH_DEF;
    localparam int CAPACITY      = MAX_ITEMS_DEF;
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int IDLE_PERCENT  = 16;
    localparam int HOLD_START    = 400;
    localparam int HOLD_LEN      = 250;
    localparam int RX_QUIET_FROM = 2500;
    localparam int RX_QUIET_TO   = 4000;
    localparam int TX_QUIET_FROM = 20;
    localparam int TX_QUIET_TO   = 120;
    localparam int LONG_AT       = 120;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VAL_MAX = ~VAL_MIN;

    // Value patterns of the random arrays.
    typedef enum int {
        PAT_FULL,
        PAT_TIES,
        PAT_RISING,
        PAT_EXTREMES
    } t_pattern;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               i_last_item = 1'b0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [IDX_OUT_W-1:0] o_node_index;
    logic               o_has_parent;
    logic [IDX_OUT_W-1:0] o_parent_index;
    logic               o_has_left;
    logic [IDX_OUT_W-1:0] o_left_index;
    logic               o_end_of_array;
    logic [IDX_OUT_W-1:0] o_root_index;
    logic               o_overflow;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count  = 0;
    int unsigned rx_cycle     = 0;
    bit          quiet_sender = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    min_cartesian_tree_builder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_node_index   (o_node_index),
        .o_has_parent   (o_has_parent),
        .o_parent_index (o_parent_index),
        .o_has_left     (o_has_left),
        .o_left_index   (o_left_index),
        .o_end_of_array (o_end_of_array),
        .o_root_index   (o_root_index),
        .o_overflow     (o_overflow)
    );

    mct_link_checker link_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_value     (i_value),
        .i_in_last      (i_last_item),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_node_index   (o_node_index),
        .i_has_parent   (o_has_parent),
        .i_parent_index (o_parent_index),
        .i_has_left     (o_has_left),
        .i_left_index   (o_left_index),
        .i_end_of_array (o_end_of_array),
        .i_root_index   (o_root_index),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    // Guard against a hang: the run is cut off far beyond its normal length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver side. It counts its own cycles: one long hold-off early in the
    // run, a quiet window with no stalls later, random stalls elsewhere.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            i_stall = 1'b1;
        end else if (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO) begin
            i_stall = 1'b0;
        end else begin
            i_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Offers one item at the falling edge and holds it until a rising edge
    // takes it. Valid is lowered only for a random gap, never just to be
    // raised again by the next item.
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
        i_valid     = 1'b1;
        i_value     = value;
        i_last_item = last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (!quiet_sender && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input t_pattern pattern,
                                                     input logic [VALUE_W-1:0] prev);
        logic [VALUE_W-1:0] v;
        case (pattern)
            PAT_FULL: begin
                v = VALUE_W'($urandom);
            end
            PAT_TIES: begin
                v = VALUE_W'(int'($urandom_range(0, 8)) - 4);
            end
            PAT_RISING: begin
                // Mostly rising with repeats, and now and then a drop that
                // pops a run of entries.
                if ($urandom_range(0, 7) == 0) begin
                    v = prev - VALUE_W'($urandom_range(0, 50));
                end else begin
                    v = prev + VALUE_W'($urandom_range(0, 3));
                end
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_array(input int length, input t_pattern pattern);
        logic [VALUE_W-1:0] v;
        v = pick_value(PAT_FULL, '0);
        for (int i = 0; i < length; i++) begin
            v = pick_value(pattern, v);
            send_item(v, i == length - 1);
        end
    endtask

    initial begin
        int  random_sent;
        int  len;
        bit  long_done;
        random_sent = 0;
        long_done   = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // A single element array is its own root.
        send_item('0, 1'b1);
        // Equal values: each keeps the earlier one as its parent.
        send_item(VALUE_W'(7), 1'b0);
        send_item(VALUE_W'(7), 1'b0);
        send_item(VALUE_W'(7), 1'b0);
        send_item(VALUE_W'(7), 1'b1);
        // Extremes alternate, so each minimum pops the maximum before it.
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);
        // A rising chain, then the minimum pops it all and becomes the root.
        send_item(VALUE_W'(-3), 1'b0);
        send_item(VALUE_W'(-2), 1'b0);
        send_item(VALUE_W'(-1), 1'b0);
        send_item('0, 1'b0);
        send_item(VALUE_W'(1), 1'b0);
        send_item(VALUE_W'(2), 1'b0);
        send_item(VAL_MIN, 1'b1);
        // A falling chain: every item after the first pops exactly one entry.
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX - 1, 1'b0);
        send_item(VALUE_W'(32'h5555_5555), 1'b0);
        send_item(VALUE_W'(32'hAAAA_AAAA), 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            quiet_sender = (random_sent >= TX_QUIET_FROM && random_sent < TX_QUIET_TO);
            if (!long_done && random_sent >= LONG_AT) begin
                // Past the capacity the tail items are dropped, the final one
                // among them, which still reports the root.
                len = CAPACITY + int'($urandom_range(1, 4));
                send_array(len, t_pattern'($urandom_range(0, 3)));
                random_sent += len;
                long_done = 1'b1;
                // Pause until the block has handed back every result.
                i_valid = 1'b0;
                while (pending_count != 0) @(negedge i_clk);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40);
                send_array(len, t_pattern'($urandom_range(0, 3)));
                random_sent += len;
            end
        end

        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/mct_pkg.sv
hdl/mct_stack_ram.sv
hdl/mct_ctrl.sv
hdl/min_cartesian_tree_builder.sv
verif/mct_link_checker.sv
verif/tb.sv
